>>> sv/sfs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer.
// ---------------------------------------------------------------------------
package sfs_pkg;

  localparam int FRAMES    = 64;
  localparam int FIDX_W    = $clog2(FRAMES);
  localparam int FCNT_W    = 7;
  localparam int ADV       = 15;
  localparam int STEP_W    = $clog2(ADV + 1);
  localparam int TOTAL_W   = 22;
  localparam int NT_W      = 16;
  localparam int DEN_W     = TOTAL_W + 8;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_LOAD   = 3'd5;

  localparam logic [1:0] MODE_ONCE  = 2'd0;
  localparam logic [1:0] MODE_LOOP  = 2'd1;
  localparam logic [1:0] MODE_PPONG = 2'd2;
  localparam logic [1:0] MODE_CLAMP = 2'd3;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_SPEED = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] delta_time;
    logic        restart;
    logic [5:0]  load_index;
    logic [15:0] load_duration;
    logic [7:0]  load_event;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  event_id;
    logic [5:0]  frame_index;
    logic [15:0] normalized_time;
    logic        playing;
    logic        paused;
    logic        finished;
    logic        reversing;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic playing;
    logic paused;
    logic finished;
    logic reversing;
  } run_flags_t;

endpackage

>>> sv/sfs_channels.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfs channels
// Valid/ready channel interfaces for items, results and register writes.
// ---------------------------------------------------------------------------
interface sfs_in_if;
  logic              valid;
  logic              ready;
  sfs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfs_out_if;
  logic               valid;
  logic               ready;
  sfs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfs_cfg_if;
  logic               valid;
  logic               ready;
  sfs_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/sfs_norm_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfs_norm_div
// Restoring divider, one quotient bit per cycle, for normalized time.
// ---------------------------------------------------------------------------
module sfs_norm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sfs_pkg::DEN_W-1:0]  num,
  input  logic [sfs_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [sfs_pkg::NT_W-1:0]   quo
);

  localparam int CNT_W = $clog2(sfs_pkg::NT_W + 1);

  logic [sfs_pkg::DEN_W-1:0] rem_r;
  logic [sfs_pkg::DEN_W-1:0] den_r;
  logic [sfs_pkg::NT_W-1:0]  quo_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      done_r;
  logic [sfs_pkg::DEN_W:0]   trial;
  logic                      ge;

  // num < den on entry, so the partial remainder stays below den
  assign trial = {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= num;
        den_r <= den;
        cnt_r <= CNT_W'(sfs_pkg::NT_W);
      end else if (cnt_r != '0) begin
        rem_r <= ge ? sfs_pkg::DEN_W'(trial - {1'b0, den_r}) : trial[sfs_pkg::DEN_W-1:0];
        quo_r <= {quo_r[sfs_pkg::NT_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> sv/sprite_frame_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_frame_sequencer
// Frame table walker with play modes, frame events and normalized time.
// ---------------------------------------------------------------------------
// One item is handled at a time. A tick passes at most 15 frames, each with
// a frame table read and then an evaluate, then does the start-time read and
// the bit-serial normalized-time divide; result words go out one per cycle
// while the output is not stalled. A load item and a frame_count write run
// a sweep over the frame table that rebuilds the start times; other control
// items go on to the start-time read. The frame table and the start-time
// table are simple dual-port memories with registered read data. A register
// write takes priority over an input item offered in the same cycle.
module sprite_frame_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  sfs_in_if.sink          in_ch,
  sfs_out_if.source       out_ch,
  sfs_cfg_if.sink         cfg_ch
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_REB   = 4'd1;
  localparam logic [3:0] S_TADD  = 4'd2;
  localparam logic [3:0] S_WRD   = 4'd3;
  localparam logic [3:0] S_WEV   = 4'd4;
  localparam logic [3:0] S_NRD   = 4'd5;
  localparam logic [3:0] S_NCALC = 4'd6;
  localparam logic [3:0] S_NDIV  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  localparam int FI = sfs_pkg::FIDX_W;
  localparam int FC = sfs_pkg::FCNT_W;
  localparam int TW = sfs_pkg::TOTAL_W;
  localparam int SW = sfs_pkg::STEP_W;

  logic [3:0]            state_r;
  logic [1:0]            mode_r;
  logic [15:0]           speed_r;
  logic [FC-1:0]         fcnt_r;
  logic [TW-1:0]         total_r;
  logic [TW-1:0]         acc_r;
  logic [31:0]           timer_r;
  logic [31:0]           dt_r;
  logic [FI-1:0]         cf_r;
  sfs_pkg::run_flags_t   flags_r;
  logic [FC-1:0]         reb_cnt_r;
  logic                  reb_pv_r;
  logic [FI-1:0]         reb_pidx_r;
  logic                  reb_item_r;
  logic [SW-1:0]         steps_r;
  logic [7:0]            evq_r [sfs_pkg::ADV];
  logic [SW-1:0]         evn_r;
  logic [SW-1:0]         eptr_r;
  logic [15:0]           nt_r;
  logic                  out_v_r;
  sfs_pkg::out_item_t    out_r;

  logic [23:0]           dur_mem [sfs_pkg::FRAMES];
  logic [TW-1:0]         st_mem  [sfs_pkg::FRAMES];
  logic [23:0]           dm_rd_r;
  logic [TW-1:0]         st_rd_r;

  logic                  in_acc;
  logic                  cfg_acc;
  logic [FC-1:0]         n_act;
  logic [FI-1:0]         rd_addr;
  logic [23:0]           dlen;
  logic [7:0]            cur_ev;
  logic [32:0]           tsum;
  logic [SW-1:0]         steps_n;
  logic [FC-1:0]         cf_ext;
  logic [32:0]           num_full;
  logic [sfs_pkg::DEN_W-1:0] den;
  logic                  div_start;
  logic                  div_done;
  logic [15:0]           div_q;

  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign n_act   = (fcnt_r > FC'(sfs_pkg::FRAMES)) ? FC'(sfs_pkg::FRAMES) : fcnt_r;
  assign rd_addr = (state_r == S_REB) ? reb_cnt_r[FI-1:0] : cf_r;
  assign dlen    = {dm_rd_r[15:0], 8'd0};
  assign cur_ev  = dm_rd_r[23:16];
  assign tsum    = {1'b0, timer_r} + {1'b0, dt_r};
  assign steps_n = steps_r + SW'(1);
  assign cf_ext  = FC'(cf_r);
  assign num_full = {3'd0, st_rd_r, 8'd0} + {1'b0, timer_r};
  assign den      = {total_r, 8'd0};
  assign div_start = (state_r == S_NCALC) && (total_r != '0) && (cf_ext < n_act)
                     && (num_full < {3'd0, den});

  // frame table: {event, duration}
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.data.op == sfs_pkg::OP_LOAD) begin
      dur_mem[in_ch.data.load_index] <= {in_ch.data.load_event, in_ch.data.load_duration};
    end
    dm_rd_r <= dur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (reb_pv_r) begin
      st_mem[reb_pidx_r] <= acc_r;
    end
    st_rd_r <= st_mem[cf_r];
  end

  sfs_norm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_full[sfs_pkg::DEN_W-1:0]),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= sfs_pkg::MODE_LOOP;
      speed_r   <= 16'd256;
      fcnt_r    <= '0;
      total_r   <= '0;
      timer_r   <= '0;
      cf_r      <= '0;
      flags_r   <= '{playing: 1'b0, paused: 1'b0, finished: 1'b1, reversing: 1'b0};
      reb_pv_r  <= 1'b0;
      reb_cnt_r <= '0;
      evn_r     <= '0;
      eptr_r    <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_acc) begin
            case (cfg_ch.data.index)
              sfs_pkg::CFG_MODE:  mode_r  <= cfg_ch.data.value[1:0];
              sfs_pkg::CFG_SPEED: speed_r <= cfg_ch.data.value;
              sfs_pkg::CFG_COUNT: begin
                fcnt_r     <= cfg_ch.data.value[FC-1:0];
                reb_cnt_r  <= '0;
                acc_r      <= '0;
                reb_item_r <= 1'b0;
                state_r    <= S_REB;
              end
              default: ;
            endcase
          end else if (in_acc) begin
            evn_r   <= '0;
            eptr_r  <= '0;
            state_r <= S_NRD;
            case (in_ch.data.op)
              sfs_pkg::OP_TICK: begin
                if (flags_r.playing && !flags_r.paused && !flags_r.finished
                    && n_act != '0) begin
                  if (cf_ext >= n_act) begin
                    cf_r <= FI'(n_act - FC'(1));
                  end
                  dt_r    <= 32'(in_ch.data.delta_time) * 32'(speed_r);
                  steps_r <= '0;
                  state_r <= S_TADD;
                end
              end
              sfs_pkg::OP_PLAY: begin
                if (!(flags_r.playing && !in_ch.data.restart)) begin
                  cf_r    <= '0;
                  timer_r <= '0;
                  flags_r <= '{playing: 1'b1, paused: 1'b0, finished: 1'b0,
                               reversing: 1'b0};
                end
              end
              sfs_pkg::OP_STOP: begin
                flags_r.playing  <= 1'b0;
                flags_r.paused   <= 1'b0;
                flags_r.finished <= 1'b1;
                cf_r    <= '0;
                timer_r <= '0;
              end
              sfs_pkg::OP_PAUSE:  flags_r.paused <= 1'b1;
              sfs_pkg::OP_RESUME: flags_r.paused <= 1'b0;
              sfs_pkg::OP_LOAD: begin
                reb_cnt_r  <= '0;
                acc_r      <= '0;
                reb_item_r <= 1'b1;
                state_r    <= S_REB;
              end
              default: ;
            endcase
          end
        end
        S_REB: begin
          // sweep the table: issue a read, then store the running start time
          if (reb_cnt_r < FC'(sfs_pkg::FRAMES)) begin
            reb_cnt_r <= reb_cnt_r + FC'(1);
          end
          reb_pv_r   <= reb_cnt_r < FC'(sfs_pkg::FRAMES);
          reb_pidx_r <= reb_cnt_r[FI-1:0];
          if (reb_pv_r && FC'(reb_pidx_r) < n_act) begin
            acc_r <= acc_r + TW'(dm_rd_r[15:0]);
          end
          if (reb_cnt_r == FC'(sfs_pkg::FRAMES) && !reb_pv_r) begin
            total_r <= acc_r;
            state_r <= reb_item_r ? S_NRD : S_IDLE;
          end
        end
        S_TADD: begin
          timer_r <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
          state_r <= S_WRD;
        end
        S_WRD: state_r <= S_WEV;
        S_WEV: begin
          if (dlen == '0) begin
            timer_r <= '0;
            state_r <= S_NRD;
          end else if (timer_r < 32'(dlen)) begin
            state_r <= S_NRD;
          end else begin
            timer_r <= timer_r - 32'(dlen);
            if (cur_ev != '0) begin
              evq_r[evn_r] <= cur_ev;
              evn_r        <= evn_r + SW'(1);
            end
            steps_r <= steps_n;
            state_r <= (steps_n == SW'(sfs_pkg::ADV)) ? S_NRD : S_WRD;
            if (flags_r.reversing ? (cf_r == '0) : (cf_ext + FC'(1) >= n_act)) begin
              case (mode_r)
                sfs_pkg::MODE_ONCE: begin
                  flags_r.playing  <= 1'b0;
                  flags_r.paused   <= 1'b0;
                  flags_r.finished <= 1'b1;
                  cf_r    <= '0;
                  timer_r <= '0;
                  state_r <= S_NRD;
                end
                sfs_pkg::MODE_LOOP: begin
                  cf_r <= flags_r.reversing ? FI'(n_act - FC'(1)) : '0;
                end
                sfs_pkg::MODE_PPONG: begin
                  flags_r.reversing <= !flags_r.reversing;
                  if (flags_r.reversing) begin
                    cf_r <= (n_act > FC'(1)) ? FI'(1) : '0;
                  end else begin
                    cf_r <= (n_act > FC'(2)) ? FI'(n_act - FC'(2)) : '0;
                  end
                end
                default: begin
                  // clamp: hold at the end reached
                  cf_r <= flags_r.reversing ? '0 : FI'(n_act - FC'(1));
                  flags_r.finished <= 1'b1;
                  timer_r <= '0;
                  state_r <= S_NRD;
                end
              endcase
            end else begin
              cf_r <= flags_r.reversing ? cf_r - FI'(1) : cf_r + FI'(1);
            end
          end
        end
        S_NRD: state_r <= S_NCALC;
        S_NCALC: begin
          if (div_start) begin
            state_r <= S_NDIV;
          end else begin
            nt_r    <= (total_r == '0 || cf_ext >= n_act) ? 16'd0 : 16'hFFFF;
            state_r <= S_EMIT;
          end
        end
        S_NDIV: begin
          if (div_done) begin
            nt_r    <= div_q;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_v_r || out_ch.ready) begin
            out_v_r                   <= 1'b1;
            out_r.frame_index         <= cf_r;
            out_r.normalized_time     <= nt_r;
            out_r.playing             <= flags_r.playing;
            out_r.paused              <= flags_r.paused;
            out_r.finished            <= flags_r.finished;
            out_r.reversing           <= flags_r.reversing;
            if (eptr_r < evn_r) begin
              out_r.kind     <= sfs_pkg::KIND_EVENT;
              out_r.event_id <= evq_r[eptr_r];
              out_r.last     <= 1'b0;
              eptr_r         <= eptr_r + SW'(1);
            end else begin
              out_r.kind     <= sfs_pkg::KIND_STATUS;
              out_r.event_id <= '0;
              out_r.last     <= 1'b1;
              state_r        <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

>>> sv/sfs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfs_checker
// Port-level checks on the result channel of the sprite frame sequencer.
// ---------------------------------------------------------------------------
module sfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sfs_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == sfs_pkg::KIND_STATUS |->
      out_data.event_id == 8'd0 && out_data.last)
    else $error("status word without last or with an event id");

  a_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == sfs_pkg::KIND_EVENT |->
      !out_data.last && out_data.event_id != 8'd0)
    else $error("event word marked last or with no event id");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
